// ===== rtl/gaussian_blur_5x5_rgb_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 5x5 blur
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_5X5_RGB_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_RGB_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define GB5_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define GB5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gb5_pkg.sv =====
// ----------------------------------------------------------------------------
// gb5_pkg
// Widths, codes, weight table and the job records passed between the
// front and the back of the 5x5 blur.
// ----------------------------------------------------------------------------
package gb5_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int ROW_W          = 16;
    localparam int CFG_W_W        = 12;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CHAN_W         = 8;
    localparam int PIX_W          = 3 * CHAN_W;
    localparam int SLOTS          = 8;
    localparam int SLOT_W         = $clog2(SLOTS);
    localparam int TAPS           = 5;
    localparam int COEF_FRAC_BITS = 16;
    localparam int PROD_W         = CHAN_W + COEF_FRAC_BITS;
    localparam int ACC_W          = PROD_W + 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    // Q0.32 weights indexed by squared tap distance
    localparam logic [31:0] COEF_Q32 [9] = '{
        32'd303806080, 32'd243268891, 32'd194794499, 32'd0, 32'd124898412,
        32'd100010830, 32'd0, 32'd0, 32'd51347271
    };

    // Weight of tap (dy, dx), indices 0..4 with the centre at 2, rounded half up
    function automatic logic [COEF_FRAC_BITS-1:0] tap_weight(int dy_i, int dx_i);
        int          idx;
        logic [32:0] t;
        idx = (dy_i - 2) * (dy_i - 2) + (dx_i - 2) * (dx_i - 2);
        t   = {1'b0, COEF_Q32[idx]} + (33'd1 << (31 - COEF_FRAC_BITS));
        return t[31 -: COEF_FRAC_BITS];
    endfunction

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             eof;
    } pos_t;

    typedef struct packed {
        logic                         first;
        pos_t                         pos;
        logic [TAPS-1:0][SLOT_W-1:0]  slot;
        logic [TAPS-1:0]              col_ok;
    } emit_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [COL_W-1:0]  wr_col;
        logic [PIX_W-1:0]  pixel;
        logic              emit;
        emit_t             em;
    } job_t;

endpackage

// ===== rtl/gb5_ram.sv =====
// ----------------------------------------------------------------------------
// gb5_ram
// Generic single write, single read RAM with registered read data
// (read returns the contents before a write in the same cycle).
// ----------------------------------------------------------------------------
module gb5_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Store and fetch
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gb5_fifo.sv =====
// ----------------------------------------------------------------------------
// gb5_fifo
// Short job queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`include "gaussian_blur_5x5_rgb_assert.svh"

module gb5_fifo import gb5_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    output logic full,
    input  logic pop,
    output job_t dout,
    output logic empty
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    `GB5_ASSERT_SAME(a_no_overflow, push, count_reg < (QPTR_W+1)'(QUEUE_DEPTH), "queue overflow")
    `GB5_ASSERT_SAME(a_no_underflow, pop, count_reg != '0, "queue underflow")

endmodule

// ===== rtl/gb5_front.sv =====
// ----------------------------------------------------------------------------
// gb5_front
// Accepts items, tracks input and output positions, decides whether an item
// emits a pixel and works out its row slots and border columns.
// ----------------------------------------------------------------------------
module gb5_front import gb5_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  logic                  kind,
    input  logic [CHAN_W-1:0]     chan_0,
    input  logic [CHAN_W-1:0]     chan_1,
    input  logic [CHAN_W-1:0]     chan_2,
    input  logic                  q_full,
    output logic                  push,
    output job_t                  job
);

    logic [CFG_W_W-1:0] width_reg, width_next;
    logic [ROW_W-1:0]   height_reg, height_next;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]   em_col_reg, em_col_next;
    logic [ROW_W-1:0]   em_row_reg, em_row_next;
    logic               done_reg, done_next;

    logic [COL_W:0]     w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               accept, is_px, restart, rdy, last;
    logic [COL_W-1:0]   in_col0, in_col1, em_col0;
    logic [ROW_W-1:0]   in_row0, in_row1, em_row0;
    logic               done0, done1;
    logic [COL_W:0]     in_col_inc, em_col_p2, nc, em_col_inc;
    logic [ROW_W:0]     in_row_inc, em_row_p2, nr, em_row_inc;
    logic               row_ok;
    logic [ROW_W-1:0]   rr;

    always_comb
    begin
        // Effective frame size
        if (width_reg == '0)
        begin
            w_eff = (COL_W+1)'(1);
        end
        else if (width_reg > (CFG_W_W)'(MAX_WIDTH))
        begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (COL_W+1)'(width_reg);
        end
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;

        accept  = pixel_valid && !q_full;
        is_px   = (kind_t'(kind) == KIND_PIXEL);
        restart = is_px && done_reg;

        // A pixel after a complete frame starts the next one
        in_col0 = restart ? '0 : in_col_reg;
        in_row0 = restart ? '0 : in_row_reg;
        em_col0 = restart ? '0 : em_col_reg;
        em_row0 = restart ? '0 : em_row_reg;
        done0   = restart ? 1'b0 : done_reg;

        // Advance the input position
        in_col_inc = {1'b0, in_col0} + 1'b1;
        in_row_inc = {1'b0, in_row0} + 1'b1;
        in_col1    = in_col0;
        in_row1    = in_row0;
        done1      = done0;
        if (is_px)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_col1 = '0;
                if (in_row_inc >= {1'b0, h_eff})
                begin
                    in_row1 = '0;
                    done1   = 1'b1;
                end
                else
                begin
                    in_row1 = in_row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                in_col1 = in_col_inc[COL_W-1:0];
            end
        end

        // Output is ready once its lower right neighbour has arrived
        em_row_p2 = {1'b0, em_row0} + (ROW_W+1)'(2);
        em_col_p2 = {1'b0, em_col0} + (COL_W+1)'(2);
        nr = (em_row_p2 < {1'b0, h_eff}) ? em_row_p2 : {1'b0, h_eff} - 1'b1;
        nc = (em_col_p2 < w_eff) ? em_col_p2 : w_eff - 1'b1;
        rdy = done1 || ({1'b0, in_row1} > nr)
              || (({1'b0, in_row1} == nr) && ({1'b0, in_col1} > nc));
        last = (em_row0 == h_eff - 1'b1) && ({1'b0, em_col0} == w_eff - 1'b1);

        // Build the job
        job.wr_en         = is_px;
        job.wr_slot       = in_row0[SLOT_W-1:0];
        job.wr_col        = in_col0;
        job.pixel         = {chan_2, chan_1, chan_0};
        job.emit          = rdy;
        job.em.first      = (em_col0 == '0);
        job.em.pos.col    = em_col0;
        job.em.pos.row    = em_row0;
        job.em.pos.eof    = last;
        for (int k = 0; k < TAPS; k++)
        begin
            // Rows outside the frame fall back to the centre row
            if (k < 2)
            begin
                row_ok = (em_row0 >= ROW_W'(2 - k));
            end
            else
            begin
                row_ok = (({1'b0, em_row0} + (ROW_W+1)'(k - 2)) < {1'b0, h_eff});
            end
            rr = row_ok ? (em_row0 + ROW_W'(k) - ROW_W'(2)) : em_row0;
            job.em.slot[k] = rr[SLOT_W-1:0];

            // Columns outside the frame fall back to the centre column
            if (k < 2)
            begin
                job.em.col_ok[k] = (em_col0 >= COL_W'(2 - k));
            end
            else
            begin
                job.em.col_ok[k] = (({1'b0, em_col0} + (COL_W+1)'(k - 2)) < w_eff);
            end
        end

        push        = accept && (is_px || rdy);
        pixel_ready = !q_full;

        // Next state
        width_next  = width_reg;
        height_next = height_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        em_col_next = em_col_reg;
        em_row_next = em_row_reg;
        done_next   = done_reg;
        em_col_inc  = {1'b0, em_col0} + 1'b1;
        em_row_inc  = {1'b0, em_row0} + 1'b1;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_next  = cfg_data[CFG_W_W-1:0];
                CFG_HEIGHT: height_next = cfg_data[ROW_W-1:0];
                default:    width_next  = width_reg;
            endcase
            in_col_next = '0;
            in_row_next = '0;
            em_col_next = '0;
            em_row_next = '0;
            done_next   = 1'b0;
        end
        else if (accept)
        begin
            in_col_next = in_col1;
            in_row_next = in_row1;
            done_next   = done1;
            em_col_next = em_col0;
            em_row_next = em_row0;
            if (rdy)
            begin
                if (last)
                begin
                    in_col_next = '0;
                    in_row_next = '0;
                    em_col_next = '0;
                    em_row_next = '0;
                    done_next   = 1'b0;
                end
                else if (em_col_inc >= w_eff)
                begin
                    em_col_next = '0;
                    em_row_next = em_row_inc[ROW_W-1:0];
                end
                else
                begin
                    em_col_next = em_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W_W'(640);
            height_reg <= ROW_W'(480);
            in_col_reg <= '0;
            in_row_reg <= '0;
            em_col_reg <= '0;
            em_row_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            em_col_reg <= em_col_next;
            em_row_reg <= em_row_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== rtl/gb5_back.sv =====
// ----------------------------------------------------------------------------
// gb5_back
// Executes queued jobs in order: writes pixels into the row banks, reads tap
// columns into the 5x5 window, weights the taps and sums them per channel.
// ----------------------------------------------------------------------------
`include "gaussian_blur_5x5_rgb_assert.svh"

module gb5_back import gb5_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  job_t              q_job,
    output logic              pop,
    output logic              blur_valid,
    input  logic              blur_ready,
    output logic [CHAN_W-1:0] blur_0,
    output logic [CHAN_W-1:0] blur_1,
    output logic [CHAN_W-1:0] blur_2,
    output logic [COL_W-1:0]  out_column,
    output logic [ROW_W-1:0]  out_row,
    output logic              end_of_frame
);

    logic              advance;
    logic              b_valid_reg, b_valid_next;
    emit_t             b_emit_reg, b_emit_next;
    logic [1:0]        rd_cnt_reg, rd_cnt_next;
    logic              b_last, b_free;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic [PIX_W-1:0]  bank_rdata [SLOTS];

    logic              c_valid_reg, c_last_reg;
    emit_t             c_emit_reg;
    logic [PIX_W-1:0]  win_reg [TAPS][TAPS];
    logic              d_valid_reg;
    emit_t             d_emit_reg;
    logic [PROD_W-1:0] prod [TAPS][TAPS][3];
    logic [PROD_W-1:0] e_prod_reg [TAPS][TAPS][3];
    logic              e_valid_reg;
    pos_t              e_pos_reg;
    logic [ACC_W-1:0]  rsum [TAPS][3];
    logic [ACC_W-1:0]  f_rsum_reg [TAPS][3];
    logic              f_valid_reg;
    pos_t              f_pos_reg;
    logic [ACC_W-1:0]  total [3];
    logic              out_valid_reg;
    pos_t              out_pos_reg;
    logic [CHAN_W-1:0] out_blur_reg [3];
    logic [PIX_W-1:0]  tap;

    // Whole pipeline moves unless the output item waits
    assign advance = !out_valid_reg || blur_ready;

    // Tap read stage: three reads at the start of a row, one otherwise
    always_comb
    begin
        b_last  = b_valid_reg && (!b_emit_reg.first || (rd_cnt_reg == 2'd2));
        b_free  = !b_valid_reg || b_last;
        pop     = advance && !q_empty && b_free;
        rd_en   = advance && b_valid_reg;
        rd_addr = b_emit_reg.first ? COL_W'(rd_cnt_reg)
                                   : b_emit_reg.pos.col + COL_W'(2);

        b_valid_next = b_valid_reg;
        b_emit_next  = b_emit_reg;
        rd_cnt_next  = rd_cnt_reg;
        if (advance)
        begin
            if (pop)
            begin
                b_valid_next = q_job.emit;
                b_emit_next  = q_job.em;
                rd_cnt_next  = 2'd0;
            end
            else if (b_last)
            begin
                b_valid_next = 1'b0;
            end
            else if (b_valid_reg)
            begin
                rd_cnt_next = rd_cnt_reg + 2'd1;
            end
        end
    end

    // Row banks, one per line slot
    for (genvar s = 0; s < SLOTS; s++)
    begin : g_bank
        gb5_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk   (clk),
            .we    (pop && q_job.wr_en && (q_job.wr_slot == SLOT_W'(s))),
            .waddr (q_job.wr_col),
            .wdata (q_job.pixel),
            .re    (rd_en),
            .raddr (rd_addr),
            .rdata (bank_rdata[s])
        );
    end

    // Weight each tap, substituting the centre column at the borders
    always_comb
    begin
        for (int dy = 0; dy < TAPS; dy++)
        begin
            for (int dx = 0; dx < TAPS; dx++)
            begin
                tap = d_emit_reg.col_ok[dx] ? win_reg[dy][dx] : win_reg[dy][2];
                for (int ch = 0; ch < 3; ch++)
                begin
                    prod[dy][dx][ch] = PROD_W'(tap[CHAN_W*ch +: CHAN_W])
                                       * PROD_W'(tap_weight(dy, dx));
                end
            end
        end
    end

    // Sum each tap row
    always_comb
    begin
        for (int dy = 0; dy < TAPS; dy++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                rsum[dy][ch] = '0;
                for (int dx = 0; dx < TAPS; dx++)
                begin
                    rsum[dy][ch] = rsum[dy][ch] + ACC_W'(e_prod_reg[dy][dx][ch]);
                end
            end
        end
    end

    // Sum the rows
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            total[ch] = '0;
            for (int dy = 0; dy < TAPS; dy++)
            begin
                total[ch] = total[ch] + f_rsum_reg[dy][ch];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            rd_cnt_reg    <= 2'd0;
            c_valid_reg   <= 1'b0;
            c_last_reg    <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            rd_cnt_reg  <= rd_cnt_next;
            if (advance)
            begin
                c_valid_reg   <= b_valid_reg;
                c_last_reg    <= b_last;
                d_valid_reg   <= c_valid_reg && c_last_reg;
                e_valid_reg   <= d_valid_reg;
                f_valid_reg   <= e_valid_reg;
                out_valid_reg <= f_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        b_emit_reg <= b_emit_next;
        if (advance)
        begin
            c_emit_reg <= b_emit_reg;
            if (c_valid_reg)
            begin
                // Shift the window left and take the new column
                for (int dy = 0; dy < TAPS; dy++)
                begin
                    for (int x = 0; x < TAPS - 1; x++)
                    begin
                        win_reg[dy][x] <= win_reg[dy][x+1];
                    end
                    win_reg[dy][TAPS-1] <= bank_rdata[c_emit_reg.slot[dy]];
                end
            end
            d_emit_reg <= c_emit_reg;
            e_prod_reg <= prod;
            e_pos_reg  <= d_emit_reg.pos;
            f_rsum_reg <= rsum;
            f_pos_reg  <= e_pos_reg;
            out_pos_reg <= f_pos_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                out_blur_reg[ch] <= total[ch][COEF_FRAC_BITS +: CHAN_W];
            end
        end
    end

    assign blur_valid   = out_valid_reg;
    assign blur_0       = out_blur_reg[0];
    assign blur_1       = out_blur_reg[1];
    assign blur_2       = out_blur_reg[2];
    assign out_column   = out_pos_reg.col;
    assign out_row      = out_pos_reg.row;
    assign end_of_frame = out_pos_reg.eof;

    `GB5_ASSERT_SAME(a_rd_cnt_range, b_valid_reg, rd_cnt_reg != 2'd3, "tap read count out of range")
    `GB5_ASSERT_SAME(a_single_read, b_valid_reg && !b_emit_reg.first, rd_cnt_reg == 2'd0, "extra read mid row")
    `GB5_ASSERT_NEXT(a_window_done, advance && c_valid_reg && c_last_reg, d_valid_reg, "window not handed on")

endmodule

// ===== rtl/gaussian_blur_5x5_rgb.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb
// Streaming 5x5 Gaussian blur (sigma 1.5) of raster-order RGB888 frames.
// ----------------------------------------------------------------------------
// Items are taken one per clock while the job queue has room. An item that
// emits an output pixel at column zero of a row needs three reads in the tap
// read stage, as the eight row banks have one read port each and the window
// must load three columns; every other emitting item needs one read there, and
// the next job waits in the queue until those reads are done. A result passes
// through the tap read stage, the bank read register, the window, the weighted
// taps, the row sums and the output register, and can wait behind earlier items
// in the queue or behind a stalled output. Line memory needs no clearing after
// reset. Writing either size register restarts the frame but does not flush jobs already queued.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb import gb5_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  logic                  kind,
    input  logic [CHAN_W-1:0]     chan_0,
    input  logic [CHAN_W-1:0]     chan_1,
    input  logic [CHAN_W-1:0]     chan_2,
    output logic                  blur_valid,
    input  logic                  blur_ready,
    output logic [CHAN_W-1:0]     blur_0,
    output logic [CHAN_W-1:0]     blur_1,
    output logic [CHAN_W-1:0]     blur_2,
    output logic [COL_W-1:0]      out_column,
    output logic [ROW_W-1:0]      out_row,
    output logic                  end_of_frame
);

    logic q_full, q_empty, push, pop;
    job_t push_job, head_job;

    // Classify items
    gb5_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .kind        (kind),
        .chan_0      (chan_0),
        .chan_1      (chan_1),
        .chan_2      (chan_2),
        .q_full      (q_full),
        .push        (push),
        .job         (push_job)
    );

    // Decouple front and back
    gb5_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_job),
        .full  (q_full),
        .pop   (pop),
        .dout  (head_job),
        .empty (q_empty)
    );

    // Execute jobs
    gb5_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (head_job),
        .pop          (pop),
        .blur_valid   (blur_valid),
        .blur_ready   (blur_ready),
        .blur_0       (blur_0),
        .blur_1       (blur_1),
        .blur_2       (blur_2),
        .out_column   (out_column),
        .out_row      (out_row),
        .end_of_frame (end_of_frame)
    );

endmodule

// ===== sim/tb_gaussian_blur_5x5_rgb.sv =====
// ----------------------------------------------------------------------------
// Testbench for gaussian_blur_5x5_rgb
// Drives pixel and drain items through a valid/ready stream over several frame
// sizes and checks every blurred pixel against an in-bench 5x5 filter model or a fixed expected value.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_5x5_rgb import gb5_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic [CHAN_W-1:0] b0;
        logic [CHAN_W-1:0] b1;
        logic [CHAN_W-1:0] b2;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              eof;
    } blur_px_t;

    typedef enum logic { STEP_CFG, STEP_ITEM } step_op_t;

    typedef struct {
        step_op_t        op;
        cfg_idx_t        idx;
        logic [15:0]     data;
        kind_t           kind;
        logic [7:0]      c0, c1, c2;
        bit              typed;
        blur_px_t        want;
    } step_t;

    typedef struct {
        int w;
        int h;
        int n;
    } frame_plan_t;

    // Gaussian weights in Q0.32, by squared tap distance
    localparam longint unsigned GAUSS_Q32 [9] = '{
        303806080, 243268891, 194794499, 0, 124898412, 100010830, 0, 0, 51347271
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    logic                  kind = 1'b0;
    logic [CHAN_W-1:0]     chan_0 = '0;
    logic [CHAN_W-1:0]     chan_1 = '0;
    logic [CHAN_W-1:0]     chan_2 = '0;
    logic                  blur_valid;
    logic                  blur_ready = 1'b0;
    logic [CHAN_W-1:0]     blur_0, blur_1, blur_2;
    logic [COL_W-1:0]      out_column;
    logic [ROW_W-1:0]      out_row;
    logic                  end_of_frame;

    gaussian_blur_5x5_rgb uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
        .kind(kind), .chan_0(chan_0), .chan_1(chan_1), .chan_2(chan_2),
        .blur_valid(blur_valid), .blur_ready(blur_ready),
        .blur_0(blur_0), .blur_1(blur_1), .blur_2(blur_2),
        .out_column(out_column), .out_row(out_row), .end_of_frame(end_of_frame)
    );

    // Filter model state
    logic [PIX_W-1:0] rows_mem [SLOTS*MAX_WIDTH];
    longint unsigned  gauss_w [9];
    int unsigned      wr_col, wr_row, rd_col, rd_row;
    bit               frame_in;
    logic [11:0]      width_reg;
    logic [15:0]      height_reg;

    blur_px_t pending_px [$];
    int       errors = 0;
    int       cycles = 0;
    bit       calm = 1'b0;
    int       hold_asked = 0;
    int       hold_served = 0;
    int       hold_left = 0;

    function automatic int unsigned frame_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned frame_h();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic void restart_frame();
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0; frame_in = 1'b0;
    endfunction

    // Store one accepted item and return the blurred pixel it releases, if any
    function automatic bit blur_step(input logic k, input logic [7:0] c0, c1, c2,
                                     output blur_px_t px);
        int unsigned     w, h, nr, nc;
        int              rr, cc, dy, dx, ch;
        longint unsigned acc [3];
        logic [23:0]     tap;
        w = frame_w();
        h = frame_h();
        if (k == KIND_PIXEL) begin
            if (frame_in) restart_frame();
            rows_mem[(wr_row % SLOTS) * MAX_WIDTH + wr_col] = {c2, c1, c0};
            wr_col++;
            if (wr_col >= w) begin
                wr_col = 0;
                wr_row++;
                if (wr_row >= h) begin
                    wr_row = 0;
                    frame_in = 1'b1;
                end
            end
        end
        nr = (rd_row + 2 < h) ? rd_row + 2 : h - 1;
        nc = (rd_col + 2 < w) ? rd_col + 2 : w - 1;
        if (!frame_in && !(wr_row > nr || (wr_row == nr && wr_col > nc))) return 1'b0;
        acc = '{0, 0, 0};
        for (dy = -2; dy <= 2; dy++) begin
            rr = int'(rd_row) + dy;
            if (rr < 0 || rr >= int'(h)) rr = int'(rd_row);
            for (dx = -2; dx <= 2; dx++) begin
                cc = int'(rd_col) + dx;
                if (cc < 0 || cc >= int'(w)) cc = int'(rd_col);
                tap = rows_mem[(rr % SLOTS) * MAX_WIDTH + cc];
                for (ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(tap[8*ch +: 8]) * gauss_w[dx*dx + dy*dy];
            end
        end
        px.b0  = CHAN_W'(acc[0] >> COEF_FRAC_BITS);
        px.b1  = CHAN_W'(acc[1] >> COEF_FRAC_BITS);
        px.b2  = CHAN_W'(acc[2] >> COEF_FRAC_BITS);
        px.col = COL_W'(rd_col);
        px.row = ROW_W'(rd_row);
        px.eof = (rd_row == h - 1) && (rd_col == w - 1);
        if (px.eof) restart_frame();
        else begin
            rd_col++;
            if (rd_col >= w) begin
                rd_col = 0;
                rd_row++;
            end
        end
        return 1'b1;
    endfunction

    // Clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            blur_ready <= 1'b0;
        end else
            blur_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
    end

    // Check each blurred pixel against the oldest expectation
    always @(posedge clk)
    begin
        blur_px_t got, want;
        if (rst_n && blur_valid && blur_ready) begin
            got = '{blur_0, blur_1, blur_2, out_column, out_row, end_of_frame};
            if (pending_px.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output: col %0d row %0d", out_column, out_row);
            end else begin
                want = pending_px.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp %0d/%0d/%0d c%0d r%0d e%0d, ",
                                  "got %0d/%0d/%0d c%0d r%0d e%0d"},
                                 want.b0, want.b1, want.b2, want.col, want.row, want.eof,
                                 got.b0, got.b1, got.b2, got.col, got.row, got.eof);
                end
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input logic k, input logic [7:0] c0, c1, c2,
                             input bit typed, input blur_px_t want);
        blur_px_t px;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 31) begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        kind   <= k;
        chan_0 <= c0;
        chan_1 <= c1;
        chan_2 <= c2;
        do @(posedge clk); while (!pixel_ready);
        if (blur_step(k, c0, c1, c2, px))
            pending_px.push_back(typed ? want : px);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write a size register once the block has gone quiet
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) width_reg = value[11:0];
        else height_reg = value;
        restart_frame();
    endtask

    function automatic logic [7:0] rand_chan();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        step_t       plan [$];
        frame_plan_t phases [8];
        blur_px_t    none_px, full_px, zero_px;
        int          p, i, nd;
        none_px = '0;
        full_px = '{8'd211, 8'd211, 8'd211, 11'd0, 16'd0, 1'b1};
        zero_px = '{8'd0, 8'd0, 8'd0, 11'd0, 16'd0, 1'b1};

        for (i = 0; i < 9; i++)
            gauss_w[i] = (GAUSS_Q32[i] + (64'd1 << (31 - COEF_FRAC_BITS)))
                         >> (32 - COEF_FRAC_BITS);
        for (i = 0; i < SLOTS*MAX_WIDTH; i++) rows_mem[i] = '0;
        width_reg  = 12'd640;
        height_reg = 16'd480;
        restart_frame();

        // Directed steps: reset drain, single-pixel frames, a tiny 3x2 frame
        plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_DRAIN, 8'd0, 8'd0, 8'd0,
                         1'b0, none_px});
        plan.push_back('{STEP_CFG, CFG_WIDTH, 16'd1, KIND_PIXEL, 8'd0, 8'd0, 8'd0,
                         1'b0, none_px});
        plan.push_back('{STEP_CFG, CFG_HEIGHT, 16'd1, KIND_PIXEL, 8'd0, 8'd0, 8'd0,
                         1'b0, none_px});
        plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_PIXEL, 8'd255, 8'd255, 8'd255,
                         1'b1, full_px});
        plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_PIXEL, 8'd0, 8'd0, 8'd0,
                         1'b1, zero_px});
        plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_PIXEL, 8'd255, 8'd0, 8'd128,
                         1'b0, none_px});
        plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_DRAIN, 8'd255, 8'd255, 8'd255,
                         1'b0, none_px});
        plan.push_back('{STEP_CFG, CFG_WIDTH, 16'd3, KIND_PIXEL, 8'd0, 8'd0, 8'd0,
                         1'b0, none_px});
        plan.push_back('{STEP_CFG, CFG_HEIGHT, 16'd2, KIND_PIXEL, 8'd0, 8'd0, 8'd0,
                         1'b0, none_px});
        for (i = 0; i < 6; i++)
            plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_PIXEL, (i[0] ? 8'd255 : 8'd0),
                             8'(i * 51), (i[1] ? 8'd0 : 8'd255), 1'b0, none_px});
        for (i = 0; i < 6; i++)
            plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_DRAIN, 8'd0, 8'd0, 8'd0,
                             1'b0, none_px});
        // Zero sizes act as one
        plan.push_back('{STEP_CFG, CFG_WIDTH, 16'd0, KIND_PIXEL, 8'd0, 8'd0, 8'd0,
                         1'b0, none_px});
        plan.push_back('{STEP_CFG, CFG_HEIGHT, 16'd0, KIND_PIXEL, 8'd0, 8'd0, 8'd0,
                         1'b0, none_px});
        plan.push_back('{STEP_ITEM, CFG_WIDTH, 16'd0, KIND_PIXEL, 8'd255, 8'd255, 8'd255,
                         1'b1, full_px});

        // Random phases: (width, height, items)
        phases = '{'{5, 4, 120}, '{1, 3, 40}, '{2, 2, 50}, '{0, 0, 20},
                   '{4095, 1, 60}, '{17, 65535, 120}, '{3, 7, 80}, '{33, 6, 160}};

        // Hold reset, then release it on a falling clock edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[s]) begin
            if (plan[s].op == STEP_CFG) write_reg(plan[s].idx, plan[s].data);
            else send_item(plan[s].kind, plan[s].c0, plan[s].c1, plan[s].c2,
                           plan[s].typed, plan[s].want);
        end

        for (p = 0; p < 8; p++) begin
            write_reg(CFG_WIDTH, 16'(phases[p].w));
            write_reg(CFG_HEIGHT, 16'(phases[p].h));
            calm = (p == 0);
            if (p == 5) hold_asked++;
            for (i = 0; i < phases[p].n; i++) begin
                // Pause once until every output is back
                if (p == 2 && i == 25) wait_drained();
                if ($urandom_range(99) < 12)
                    send_item(KIND_DRAIN, rand_chan(), rand_chan(), rand_chan(), 1'b0, none_px);
                else
                    send_item(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan(), 1'b0, none_px);
                // Flush some or all of a finished frame before the next one
                if (frame_in && $urandom_range(1)) begin
                    nd = $urandom_range(0, 4);
                    repeat (nd)
                        send_item(KIND_DRAIN, rand_chan(), rand_chan(), rand_chan(),
                                  1'b0, none_px);
                end
            end
            calm = 1'b0;
        end

        wait_drained();
        if (errors == 0 && pending_px.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
